/* design/tqws_pkg.sv */
`default_nettype none
package tqws_pkg;

   localparam int MAX_WORKERS_DEF = 16;

   localparam int NW_W      = 5;
   localparam int UNIT_W    = 20;
   localparam int CELL_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_PAD_W   = RSP_TDATA_W - NW_W - 2 * UNIT_W - CELL_W;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_WORKERS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL_UNITS = 2'd1;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_CELL  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [UNIT_W-1:0] units;
      logic [CELL_W-1:0] cell_no;
   } item_type;

endpackage
`default_nettype wire

/* design/two_ended_quota_work_splitter.sv */
// Splits the work units of each cell among the workers. A start item (tuser 0) divides
// total_units into per-worker quotas with a one-bit-a-cycle divider and then a pass that
// writes the quota RAM one worker a cycle. A cell item (tuser 1) is split in turns of a
// registered read of the quota RAM and an evaluation of it, one turn for each chunk it
// produces and for each zero-quota worker it passes over; an empty cell is taken up with no
// chunk. A two-item queue lets new items be accepted while earlier ones are still being
// split, and each chunk waits in an output register until it is taken. Configuration writes
// are always accepted.
`default_nettype none
module two_ended_quota_work_splitter #(
   parameter int MAX_WORKERS = tqws_pkg::MAX_WORKERS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // cell_units [19:0], zero padding above.
   input  wire logic [tqws_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // kind [0].
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // worker [4:0], chunk_units [24:5], first_unit [44:25], cell_number [60:45], zero padding.
   output logic      [tqws_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // overflow [0].
   output logic                                      rsp_tuser,
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tqws_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tqws_pkg::UNIT_W-1:0]          csr_data
);

   logic [tqws_pkg::NW_W-1:0]   num_workers_ff;
   logic [tqws_pkg::UNIT_W-1:0] total_units_ff;

   logic               queue_full, push, pop, head_valid;
   tqws_pkg::item_type push_item, head_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_workers_ff <= tqws_pkg::NW_W'(1);
         total_units_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            tqws_pkg::REG_NUM_WORKERS: num_workers_ff <= csr_data[tqws_pkg::NW_W-1:0];
            tqws_pkg::REG_TOTAL_UNITS: total_units_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   tqws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   tqws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   tqws_back #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .num_workers (num_workers_ff),
      .total_units (total_units_ff),
      .head_valid  (head_valid),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
`default_nettype wire

/* design/tqws_ram.sv */
`default_nettype none
module tqws_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]  rd_data_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule
`default_nettype wire

/* design/tqws_front.sv */
`default_nettype none
module tqws_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [tqws_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                      req_tuser,
   input  wire logic                      queue_full,
   output logic                           push,
   output tqws_pkg::item_type             push_item
);

   logic [tqws_pkg::CELL_W-1:0] cell_ff;
   logic [tqws_pkg::CELL_W-1:0] cell_in;

   assign req_tready = ~queue_full;
   assign push       = req_tvalid & ~queue_full;

   // Cells are numbered here so that the number travels with the item.
   always_comb begin
      cell_in = cell_ff;
      if (req_tuser == tqws_pkg::KIND_START) begin
         cell_in = '0;
      end else if (cell_ff != '1) begin
         cell_in = cell_ff + 1'b1;
      end
   end

   always_comb begin
      push_item.kind    = req_tuser;
      push_item.units   = req_tdata[tqws_pkg::UNIT_W-1:0];
      push_item.cell_no = cell_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else if (push) begin
         cell_ff <= cell_in;
      end
   end

endmodule
`default_nettype wire

/* design/tqws_queue.sv */
`default_nettype none
module tqws_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tqws_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output tqws_pkg::item_type      head_item
);

   tqws_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

/* design/tqws_div.sv */
`default_nettype none
module tqws_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [tqws_pkg::UNIT_W-1:0] dividend,
   input  wire logic [tqws_pkg::NW_W-1:0]   divisor,
   output logic                             busy,
   output logic      [tqws_pkg::UNIT_W-1:0] quotient,
   output logic      [tqws_pkg::NW_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(tqws_pkg::UNIT_W + 1);

   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [tqws_pkg::UNIT_W-1:0] quo_ff, quo_in;
   logic [tqws_pkg::NW_W-1:0]   rem_ff, rem_in;
   logic [tqws_pkg::NW_W-1:0]   dvs_ff, dvs_in;
   logic [tqws_pkg::NW_W:0]     shifted;
   logic                        fits;

   assign busy      = (cnt_ff != '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign shifted   = {rem_ff, quo_ff[tqws_pkg::UNIT_W-1]};
   assign fits      = (shifted >= {1'b0, dvs_ff});

   // Restoring division, one quotient bit a cycle.
   always_comb begin
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = CNT_W'(tqws_pkg::UNIT_W);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[tqws_pkg::UNIT_W-2:0], fits};
         rem_in = fits ? tqws_pkg::NW_W'(shifted - {1'b0, dvs_ff})
                       : tqws_pkg::NW_W'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

/* design/tqws_back.sv */
`default_nettype none
module tqws_back #(
   parameter int MAX_WORKERS = tqws_pkg::MAX_WORKERS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [tqws_pkg::NW_W-1:0]       num_workers,
   input  wire logic [tqws_pkg::UNIT_W-1:0]     total_units,
   input  wire logic                            head_valid,
   input  wire tqws_pkg::item_type              head_item,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [tqws_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int PW = $clog2(MAX_WORKERS + 2);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_FILL = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_EVAL = 3'd4;

   logic [2:0]                  state_ff, state_in;
   logic [PW-1:0]               low_ff, low_in, high_ff, high_in, fill_ff, fill_in;
   logic [tqws_pkg::NW_W-1:0]   nw_ff, nw_in, nw_clamp;
   logic [tqws_pkg::UNIT_W-1:0] rem_ff, rem_in, first_ff, first_in;
   logic [tqws_pkg::CELL_W-1:0] cell_ff, cell_in;

   logic                        out_valid_ff, out_valid_in;
   logic [tqws_pkg::NW_W-1:0]   out_worker_ff, out_worker_in;
   logic [tqws_pkg::UNIT_W-1:0] out_chunk_ff, out_chunk_in, out_first_ff, out_first_in;
   logic [tqws_pkg::CELL_W-1:0] out_cell_ff, out_cell_in;
   logic                        out_ovf_ff, out_ovf_in, out_last_ff, out_last_in;

   logic                        div_start, div_busy;
   logic [tqws_pkg::UNIT_W-1:0] div_quo;
   logic [tqws_pkg::NW_W-1:0]   div_rem;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr, lo_addr, hi_addr;
   logic [tqws_pkg::UNIT_W-1:0] wr_data, q_lo, q_hi;
   logic                        out_free;

   assign lo_addr  = AW'(low_ff - 1'b1);
   assign hi_addr  = AW'(high_ff - 1'b1);
   assign out_free = ~out_valid_ff | rsp_tready;

   always_comb begin
      if (num_workers == '0) begin
         nw_clamp = tqws_pkg::NW_W'(1);
      end else if (32'(num_workers) > MAX_WORKERS) begin
         nw_clamp = tqws_pkg::NW_W'(MAX_WORKERS);
      end else begin
         nw_clamp = num_workers;
      end
   end

   tqws_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (total_units),
      .divisor   (nw_clamp),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   tqws_ram #(
      .WIDTH (tqws_pkg::UNIT_W),
      .DEPTH (MAX_WORKERS)
   ) u_quota (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (lo_addr),
      .rd_data_a (q_lo),
      .rd_addr_b (hi_addr),
      .rd_data_b (q_hi)
   );

   always_comb begin
      state_in      = state_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      fill_in       = fill_ff;
      nw_in         = nw_ff;
      rem_in        = rem_ff;
      first_in      = first_ff;
      cell_in       = cell_ff;
      out_valid_in  = out_valid_ff & ~rsp_tready;
      out_worker_in = out_worker_ff;
      out_chunk_in  = out_chunk_ff;
      out_first_in  = out_first_ff;
      out_cell_in   = out_cell_ff;
      out_ovf_in    = out_ovf_ff;
      out_last_in   = out_last_ff;
      div_start     = 1'b0;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = AW'(fill_ff);
      wr_data       = '0;
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               if (head_item.kind == tqws_pkg::KIND_START) begin
                  div_start = 1'b1;
                  nw_in     = nw_clamp;
                  state_in  = S_DIV;
               end else begin
                  rem_in   = head_item.units;
                  first_in = tqws_pkg::UNIT_W'(1);
                  cell_in  = head_item.cell_no;
                  if (head_item.units == '0) begin
                     pop = 1'b1;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_DIV: begin
            if (!div_busy) begin
               fill_in  = '0;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            wr_en = 1'b1;
            if (32'(fill_ff) < 32'(nw_ff)) begin
               wr_data = div_quo + tqws_pkg::UNIT_W'(32'(fill_ff) < 32'(div_rem));
            end
            fill_in = fill_ff + 1'b1;
            if (32'(fill_ff) == MAX_WORKERS - 1) begin
               low_in   = PW'(1);
               high_in  = PW'(nw_ff);
               pop      = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (low_ff > high_ff) begin
               if (out_free) begin
                  out_valid_in  = 1'b1;
                  out_worker_in = '0;
                  out_chunk_in  = rem_ff;
                  out_first_in  = first_ff;
                  out_cell_in   = cell_ff;
                  out_ovf_in    = 1'b1;
                  out_last_in   = 1'b1;
                  pop           = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (q_lo == '0) begin
               low_in   = low_ff + 1'b1;
               state_in = S_READ;
            end else if (q_hi == '0) begin
               high_in  = high_ff - 1'b1;
               state_in = S_READ;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_first_in = first_ff;
               out_cell_in  = cell_ff;
               out_ovf_in   = 1'b0;
               if (rem_ff >= q_lo) begin
                  out_worker_in = tqws_pkg::NW_W'(low_ff);
                  out_chunk_in  = q_lo;
                  out_last_in   = (rem_ff == q_lo);
                  rem_in        = rem_ff - q_lo;
                  first_in      = first_ff + q_lo;
                  low_in        = low_ff + 1'b1;
               end else if (rem_ff >= q_hi) begin
                  out_worker_in = tqws_pkg::NW_W'(high_ff);
                  out_chunk_in  = q_hi;
                  out_last_in   = (rem_ff == q_hi);
                  rem_in        = rem_ff - q_hi;
                  first_in      = first_ff + q_hi;
                  high_in       = high_ff - 1'b1;
               end else begin
                  // The tail is charged against the high worker's quota.
                  out_worker_in = tqws_pkg::NW_W'(high_ff);
                  out_chunk_in  = rem_ff;
                  out_last_in   = 1'b1;
                  rem_in        = '0;
                  wr_en         = 1'b1;
                  wr_addr       = hi_addr;
                  wr_data       = q_hi - rem_ff;
               end
               if (out_last_in) begin
                  pop      = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      fill_ff       <= fill_in;
      nw_ff         <= nw_in;
      rem_ff        <= rem_in;
      first_ff      <= first_in;
      cell_ff       <= cell_in;
      out_worker_ff <= out_worker_in;
      out_chunk_ff  <= out_chunk_in;
      out_first_ff  <= out_first_in;
      out_cell_ff   <= out_cell_in;
      out_ovf_ff    <= out_ovf_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         low_ff       <= PW'(1);
         high_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{tqws_pkg::RSP_PAD_W{1'b0}}, out_cell_ff, out_first_ff,
                        out_chunk_ff, out_worker_ff};
   assign rsp_tuser  = out_ovf_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

/* design/tqws_checker.sv */
`default_nettype none
module tqws_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [tqws_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                             rsp_tuser,
   input wire logic                             rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_ovf_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[4:0] == 5'd0 && rsp_tlast)
      else $error("overflow item must go to worker zero and end the cell");

   a_chunk_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[4:0] != 5'd0 && rsp_tdata[24:5] != 20'd0)
      else $error("chunk item without worker or units");

   a_index_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[44:25] != 20'd0 && rsp_tdata[60:45] != 16'd0)
      else $error("chunk item with zero first unit or cell number");

endmodule

bind two_ended_quota_work_splitter tqws_checker u_tqws_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

/* test/two_ended_quota_work_splitter_test.sv */
`timescale 1ns / 100ps
module two_ended_quota_work_splitter_test;

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int SETTLE_CYCLES = 120;

   typedef struct packed {
      logic                        kind;
      logic [tqws_pkg::UNIT_W-1:0] units;
   } work_item_type;

   typedef struct packed {
      logic [tqws_pkg::NW_W-1:0]   worker;
      logic [tqws_pkg::UNIT_W-1:0] units;
      logic [tqws_pkg::UNIT_W-1:0] first;
      logic [tqws_pkg::CELL_W-1:0] cell_no;
      logic                        ovf;
      logic                        last;
   } chunk_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [tqws_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [tqws_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [tqws_pkg::CSR_IDX_W-1:0] csr_index = tqws_pkg::REG_NUM_WORKERS;
   logic [tqws_pkg::UNIT_W-1:0] csr_data = '0;

   // Shadow copy of the registers and of the splitting state.
   logic [tqws_pkg::NW_W-1:0]   cfg_workers = 5'd1;
   logic [tqws_pkg::UNIT_W-1:0] cfg_total = '0;
   logic [tqws_pkg::UNIT_W-1:0] quota [tqws_pkg::MAX_WORKERS_DEF] = '{default: '0};
   int                          low_ptr = 1;
   int                          high_ptr = 0;
   logic [tqws_pkg::CELL_W-1:0] cells_seen = '0;

   work_item_type items_to_send[$];
   chunk_rec_type chunk_expect[$];
   logic     calm = 1'b0;
   logic     mismatch_seen = 1'b0;
   int       gap_left = 0;
   int       stall_left = 0;
   int       cycle_count = 0;

   two_ended_quota_work_splitter dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int draw_gap();
      int pick;
      if (calm) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_workers(input logic [tqws_pkg::NW_W-1:0] value);
      int nw;
      nw = int'(value);
      if (nw < 1) nw = 1;
      if (nw > tqws_pkg::MAX_WORKERS_DEF) nw = tqws_pkg::MAX_WORKERS_DEF;
      return nw;
   endfunction

   function automatic chunk_rec_type chunk_of(input int worker,
                                              input logic [tqws_pkg::UNIT_W-1:0] units,
                                              input logic [tqws_pkg::UNIT_W-1:0] first,
                                              input logic ovf);
      chunk_rec_type c;
      c.worker = tqws_pkg::NW_W'(worker);
      c.units = units;
      c.first = first;
      c.cell_no = cells_seen;
      c.ovf = ovf;
      c.last = 1'b0;
      return c;
   endfunction

   task automatic start_run();
      int nw, base, extra;
      nw = clamp_workers(cfg_workers);
      base = int'(cfg_total) / nw;
      extra = int'(cfg_total) % nw;
      for (int i = 0; i < tqws_pkg::MAX_WORKERS_DEF; i++)
         quota[i] = (i < nw) ? tqws_pkg::UNIT_W'(base + ((i < extra) ? 1 : 0)) : '0;
      low_ptr = 1;
      high_ptr = nw;
      cells_seen = '0;
   endtask

   task automatic split_cell(input logic [tqws_pkg::UNIT_W-1:0] cell_units);
      logic [tqws_pkg::UNIT_W-1:0] rem, first, q;
      chunk_rec_type pieces[$];
      if (cells_seen != '1) cells_seen++;
      rem = cell_units;
      first = tqws_pkg::UNIT_W'(1);
      while (rem != 0 && pieces.size() < tqws_pkg::MAX_WORKERS_DEF + 1) begin
         while (low_ptr <= high_ptr && quota[low_ptr-1] == 0) low_ptr++;
         while (low_ptr <= high_ptr && quota[high_ptr-1] == 0) high_ptr--;
         if (low_ptr > high_ptr) begin
            pieces.push_back(chunk_of(0, rem, first, 1'b1));
            rem = '0;
         end else if (rem >= quota[low_ptr-1]) begin
            q = quota[low_ptr-1];
            pieces.push_back(chunk_of(low_ptr, q, first, 1'b0));
            quota[low_ptr-1] = '0;
            low_ptr++;
            rem -= q;
            first += q;
         end else if (rem >= quota[high_ptr-1]) begin
            q = quota[high_ptr-1];
            pieces.push_back(chunk_of(high_ptr, q, first, 1'b0));
            quota[high_ptr-1] = '0;
            high_ptr--;
            rem -= q;
            first += q;
         end else begin
            pieces.push_back(chunk_of(high_ptr, rem, first, 1'b0));
            quota[high_ptr-1] -= rem;
            rem = '0;
         end
      end
      if (pieces.size() > 0) pieces[$].last = 1'b1;
      foreach (pieces[i]) chunk_expect.push_back(pieces[i]);
   endtask

   always @(posedge clock) begin
      work_item_type nxt;
      logic          valid_next;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         valid_next = req_tvalid;
         if (req_tvalid && req_tready) begin
            if (req_tuser == tqws_pkg::KIND_START) start_run();
            else split_cell(req_tdata[tqws_pkg::UNIT_W-1:0]);
            valid_next = 1'b0;
            gap_left = draw_gap();
         end
         if (!valid_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (items_to_send.size() > 0) begin
               nxt = items_to_send.pop_front();
               req_tuser <= nxt.kind;
               req_tdata <= {{(tqws_pkg::REQ_TDATA_W - tqws_pkg::UNIT_W){1'b0}}, nxt.units};
               valid_next = 1'b1;
            end
         end
         req_tvalid <= valid_next;
      end
   end

   task automatic compare_field(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
         mismatch_seen = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      chunk_rec_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.worker = rsp_tdata[4:0];
            got.units = rsp_tdata[24:5];
            got.first = rsp_tdata[44:25];
            got.cell_no = rsp_tdata[60:45];
            got.ovf = rsp_tuser;
            got.last = rsp_tlast;
            if (chunk_expect.size() == 0) begin
               $display("%0t: unexpected chunk, expected none, got %p", $time, got);
               mismatch_seen = 1'b1;
            end else begin
               want = chunk_expect.pop_front();
               compare_field("worker", int'(want.worker), int'(got.worker));
               compare_field("chunk_units", int'(want.units), int'(got.units));
               compare_field("first_unit", int'(want.first), int'(got.first));
               compare_field("cell_number", int'(want.cell_no), int'(got.cell_no));
               compare_field("overflow", int'(want.ovf), int'(got.ovf));
               compare_field("last", int'(want.last), int'(got.last));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = draw_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [tqws_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tqws_pkg::UNIT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == tqws_pkg::REG_NUM_WORKERS) cfg_workers = value[tqws_pkg::NW_W-1:0];
      else cfg_total = value;
   endtask

   // Call only on a falling edge so the driver never sees a half-filled queue.
   task automatic send_item(input logic kind, input logic [tqws_pkg::UNIT_W-1:0] units);
      work_item_type w;
      w.kind = kind;
      w.units = units;
      items_to_send.push_back(w);
   endtask

   // Waits until the block has taken every item and returned every chunk, then lets
   // a start item that produces no chunk finish its quota pass.
   task automatic settle();
      do @(negedge clock);
      while (items_to_send.size() != 0 || req_tvalid || chunk_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_phase(input int count);
      int pick, nw, per;
      logic [tqws_pkg::UNIT_W-1:0] nw_value, total_value, units;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         nw_value = $urandom_range(0, 1) ? '0 : tqws_pkg::UNIT_W'($urandom_range(17, 31));
      end else if (pick == 1) begin
         nw_value = tqws_pkg::UNIT_W'($urandom);
      end else begin
         nw_value = tqws_pkg::UNIT_W'($urandom_range(1, 16));
      end
      pick = $urandom_range(0, 9);
      case (pick)
         0: total_value = '0;
         1: total_value = '1;
         2: total_value = tqws_pkg::UNIT_W'($urandom);
         3, 4, 5: total_value = tqws_pkg::UNIT_W'($urandom_range(1, 60));
         default: total_value = tqws_pkg::UNIT_W'($urandom_range(61, 5000));
      endcase
      nw = clamp_workers(nw_value[tqws_pkg::NW_W-1:0]);
      per = int'(total_value) / nw;
      if (per > 600000) per = 600000;
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1)) begin
         write_reg(tqws_pkg::REG_NUM_WORKERS, nw_value);
         write_reg(tqws_pkg::REG_TOTAL_UNITS, total_value);
      end else begin
         write_reg(tqws_pkg::REG_TOTAL_UNITS, total_value);
         write_reg(tqws_pkg::REG_NUM_WORKERS, nw_value);
      end
      @(negedge clock);
      send_item(tqws_pkg::KIND_START, tqws_pkg::UNIT_W'($urandom));
      repeat (count - 1) begin
         pick = $urandom_range(0, 99);
         if (pick < 7) begin
            send_item(tqws_pkg::KIND_START, tqws_pkg::UNIT_W'($urandom));
         end else begin
            if (pick < 13) units = '0;
            else if (pick < 21) units = tqws_pkg::UNIT_W'($urandom);
            else if (pick < 24) units = '1;
            else units = tqws_pkg::UNIT_W'($urandom_range(1, per + per / 2 + 2));
            send_item(tqws_pkg::KIND_CELL, units);
         end
      end
      settle();
      calm = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Cells before any start, then a start with the reset register values.
      @(negedge clock);
      send_item(tqws_pkg::KIND_CELL, '0);
      send_item(tqws_pkg::KIND_CELL, 20'd5);
      send_item(tqws_pkg::KIND_CELL, '1);
      send_item(tqws_pkg::KIND_START, '1);
      send_item(tqws_pkg::KIND_CELL, 20'd7);
      settle();

      // Uneven quotas of 3, 3, 2 and 2 worked from both ends until overflow.
      write_reg(tqws_pkg::REG_NUM_WORKERS, 20'd4);
      write_reg(tqws_pkg::REG_TOTAL_UNITS, 20'd10);
      @(negedge clock);
      send_item(tqws_pkg::KIND_START, '0);
      send_item(tqws_pkg::KIND_CELL, 20'd1);
      send_item(tqws_pkg::KIND_CELL, 20'd3);
      send_item(tqws_pkg::KIND_CELL, '0);
      send_item(tqws_pkg::KIND_CELL, 20'd4);
      send_item(tqws_pkg::KIND_CELL, 20'd2);
      send_item(tqws_pkg::KIND_CELL, 20'd9);
      settle();

      // A worker count of zero acts as one; the full total goes to a single worker.
      write_reg(tqws_pkg::REG_NUM_WORKERS, '0);
      write_reg(tqws_pkg::REG_TOTAL_UNITS, '1);
      @(negedge clock);
      send_item(tqws_pkg::KIND_START, 20'h5A5A5);
      send_item(tqws_pkg::KIND_CELL, '1);
      send_item(tqws_pkg::KIND_CELL, 20'd1);
      settle();

      // An oversized worker count is clamped to the maximum.
      write_reg(tqws_pkg::REG_NUM_WORKERS, '1);
      write_reg(tqws_pkg::REG_TOTAL_UNITS, 20'd20);
      @(negedge clock);
      send_item(tqws_pkg::KIND_START, '0);
      send_item(tqws_pkg::KIND_CELL, 20'd20);
      send_item(tqws_pkg::KIND_CELL, 20'd3);
      settle();

      // Most workers have a zero quota and must be passed over.
      write_reg(tqws_pkg::REG_NUM_WORKERS, 20'd16);
      write_reg(tqws_pkg::REG_TOTAL_UNITS, 20'd5);
      @(negedge clock);
      send_item(tqws_pkg::KIND_START, '0);
      send_item(tqws_pkg::KIND_CELL, 20'd40);
      send_item(tqws_pkg::KIND_START, '0);
      send_item(tqws_pkg::KIND_CELL, 20'd2);
      send_item(tqws_pkg::KIND_CELL, 20'd1);
      settle();

      // Every worker takes a whole quota and the rest overflows: the longest chunk burst.
      write_reg(tqws_pkg::REG_TOTAL_UNITS, 20'd32);
      @(negedge clock);
      send_item(tqws_pkg::KIND_START, '0);
      send_item(tqws_pkg::KIND_CELL, 20'd40);
      settle();

      repeat (8) random_phase(56);

      random_phase(20);

      if (!mismatch_seen && chunk_expect.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
